// ----- hdl/mst_pkg.sv -----
// shared types and codes for the multi-slot software timer
// command and result codes, item structs, slot entry and state encoding
// no dependencies
`default_nettype none

package mst_pkg;

  localparam int MaxResults = 8;

  // command kinds
  localparam logic [2:0] KindOneShot   = 3'd0;
  localparam logic [2:0] KindPeriodic  = 3'd1;
  localparam logic [2:0] KindEnable    = 3'd2;
  localparam logic [2:0] KindDisable   = 3'd3;
  localparam logic [2:0] KindDelete    = 3'd4;
  localparam logic [2:0] KindDeleteAll = 3'd5;
  localparam logic [2:0] KindTick      = 3'd6;

  // result kinds
  localparam logic [2:0] RkCreated  = 3'd0;
  localparam logic [2:0] RkRejected = 3'd1;
  localparam logic [2:0] RkFull     = 3'd2;
  localparam logic [2:0] RkAck      = 3'd3;
  localparam logic [2:0] RkFired    = 3'd4;
  localparam logic [2:0] RkQuiet    = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [31:0] duration;
    logic [31:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [2:0] slot_out;
    logic       last;
  } out_item_t;

  // one slot in the timer memory, a zero period marks a one-shot slot
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] remaining;
  } slot_entry_t;

  typedef struct packed {
    logic        fire;
    logic        periodic;
    logic [31:0] next_remaining;
  } tick_res_t;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StCreate = 4'b0010,
    StTick   = 4'b0100,
    StDone   = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/mst_tick_unit.sv -----
// shared compare/subtract unit used by the tick walk, one slot at a time
// depends on mst_pkg
`default_nettype none

module mst_tick_unit (
  input  wire mst_pkg::slot_entry_t entry_i,
  input  wire [31:0]                elapsed_i,
  output mst_pkg::tick_res_t        res_o
);
  import mst_pkg::*;

  logic [32:0] diff;

  // borrow or zero difference means remaining <= elapsed
  assign diff = {1'b0, entry_i.remaining} - {1'b0, elapsed_i};

  always_comb begin
    res_o.fire           = diff[32] || (diff[31:0] == 32'd0);
    res_o.periodic       = (entry_i.period != 32'd0);
    res_o.next_remaining = res_o.fire ? entry_i.period : diff[31:0];
  end

endmodule

`default_nettype wire

// ----- hdl/multi_slot_software_timer_core.sv -----
// top level of the multi-slot software timer: sequencer, slot flags, slot memory
// depends on mst_pkg and mst_tick_unit
`default_nettype none

// Timer table of NUM_SLOTS slots driven by one command per input transfer.
// The block takes one command at a time; a result waiting in the output
// register does not hold off the next command. A create walks the used
// slots in search of the lowest free one; a tick walks every slot, and
// each running slot needs one read of the single-port slot memory and one
// pass through the shared compare/subtract unit. Output stalls stretch the
// processing of a command.
module multi_slot_software_timer_core #(
  parameter int NUM_SLOTS = 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire mst_pkg::in_item_t in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output mst_pkg::out_item_t    out_item_o
);
  import mst_pkg::*;

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW = $clog2(NUM_SLOTS + 1);
  localparam int NumW = $clog2(MaxResults + 1);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                ph_q, ph_d;
  logic [NumW-1:0]     n_q, n_d;
  in_item_t            cmd_q, cmd_d;
  logic [2:0]          res_kind_q, res_kind_d;
  logic [2:0]          res_slot_q, res_slot_d;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [NUM_SLOTS-1:0] en_q, en_d;
  logic                out_valid_q;
  out_item_t           out_item_q;

  slot_entry_t         mem_q [NUM_SLOTS];
  slot_entry_t         rd_q;
  logic                mem_we;
  slot_entry_t         mem_wdata;

  logic [IdxW-1:0]     idx;
  logic [IdxW-1:0]     tgt;
  logic                slot_ok;
  logic                is_last;
  logic                out_free;
  logic                rep;
  logic                push;
  out_item_t           push_item;
  tick_res_t           tres;

  assign idx      = cnt_q[IdxW-1:0];
  assign tgt      = IdxW'(in_item_i.slot);
  assign slot_ok  = (int'(in_item_i.slot) < NUM_SLOTS);
  assign is_last  = (cnt_q == CntW'(NUM_SLOTS - 1));
  assign out_free = !out_valid_q || out_ready_i;
  assign rep      = tres.fire && (n_q < NumW'(MaxResults));

  mst_tick_unit u_tick (
    .entry_i   (rd_q),
    .elapsed_i (cmd_q.elapsed),
    .res_o     (tres)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ph_d       = ph_q;
    n_d        = n_q;
    cmd_d      = cmd_q;
    res_kind_d = res_kind_q;
    res_slot_d = res_slot_q;
    used_d     = used_q;
    en_d       = en_q;
    mem_we     = 1'b0;
    mem_wdata  = '0;
    push       = 1'b0;
    push_item  = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d      = in_item_i;
          cnt_d      = '0;
          ph_d       = 1'b0;
          n_d        = '0;
          res_slot_d = 3'd0;
          res_kind_d = RkAck;
          state_d    = StDone;
          case (in_item_i.kind)
            KindOneShot, KindPeriodic: begin
              if (in_item_i.duration == 32'd0) begin
                res_kind_d = RkRejected;
              end else begin
                state_d = StCreate;
              end
            end
            KindTick: begin
              res_kind_d = RkQuiet;
              state_d    = StTick;
            end
            KindDeleteAll: begin
              used_d = '0;
              en_d   = '0;
            end
            KindEnable: begin
              if (slot_ok && used_q[tgt]) en_d[tgt] = 1'b1;
            end
            KindDisable: begin
              if (slot_ok && used_q[tgt]) en_d[tgt] = 1'b0;
            end
            KindDelete: begin
              if (slot_ok && used_q[tgt]) begin
                used_d[tgt] = 1'b0;
                en_d[tgt]   = 1'b0;
              end
            end
            default: begin
              res_kind_d = RkAck;
            end
          endcase
        end
      end

      StCreate: begin
        if (!used_q[idx]) begin
          used_d[idx]         = 1'b1;
          en_d[idx]           = 1'b1;
          mem_we              = 1'b1;
          mem_wdata.remaining = cmd_q.duration;
          mem_wdata.period    = (cmd_q.kind == KindPeriodic) ? cmd_q.duration : 32'd0;
          res_kind_d          = RkCreated;
          res_slot_d          = 3'(cnt_q);
          state_d             = StDone;
        end else if (is_last) begin
          res_kind_d = RkFull;
          state_d    = StDone;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      StTick: begin
        if (!ph_q) begin
          if (used_q[idx] && en_q[idx]) begin
            ph_d = 1'b1;
          end else if (is_last) begin
            state_d = StDone;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end else if (!(rep && (res_kind_q == RkFired) && !out_free)) begin
          // a newly reported firing releases the one held back before it
          if (rep) begin
            if (res_kind_q == RkFired) begin
              push      = 1'b1;
              push_item = '{result_kind: RkFired, slot_out: res_slot_q, last: 1'b0};
            end
            res_kind_d = RkFired;
            res_slot_d = 3'(cnt_q);
            n_d        = n_q + NumW'(1);
          end
          if (tres.fire && !tres.periodic) begin
            used_d[idx] = 1'b0;
            en_d[idx]   = 1'b0;
          end else begin
            mem_we              = 1'b1;
            mem_wdata.period    = rd_q.period;
            mem_wdata.remaining = tres.next_remaining;
          end
          ph_d = 1'b0;
          if (is_last) begin
            state_d = StDone;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end

      StDone: begin
        if (out_free) begin
          push      = 1'b1;
          push_item = '{result_kind: res_kind_q, slot_out: res_slot_q, last: 1'b1};
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      ph_q        <= 1'b0;
      n_q         <= '0;
      used_q      <= '0;
      en_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ph_q        <= ph_d;
      n_q         <= n_d;
      used_q      <= used_d;
      en_q        <= en_d;
      out_valid_q <= push ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    res_kind_q <= res_kind_d;
    res_slot_q <= res_slot_d;
    if (push) out_item_q <= push_item;
  end

  // slot memory: one write and one registered read per cycle at the walk index
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[idx] <= mem_wdata;
    rd_q <= mem_q[idx];
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // only fired results can be followed by more results of the same command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> out_item_o.result_kind == RkFired)
    else $error("non-final result that is not a firing");

  // the compare phase only ever works on a running slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTick) && ph_q |-> used_q[idx] && en_q[idx])
    else $error("tick compare on an idle slot");

  // the walk index stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTick) || (state_q == StCreate) |-> int'(cnt_q) < NUM_SLOTS)
    else $error("slot walk out of range");

  // a zero-duration create goes straight to its rejection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.duration == 32'd0) &&
    ((in_item_i.kind == KindOneShot) || (in_item_i.kind == KindPeriodic))
    |=> (state_q == StDone) && (res_kind_q == RkRejected))
    else $error("zero-duration create not rejected");

  // never more reported firings than the result limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(n_q) <= MaxResults)
    else $error("firing count over limit");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking bench for the multi-slot software timer core
// uses mst_pkg types and codes; the slot table is mirrored here to predict every result
`default_nettype none

module tb;
  import mst_pkg::*;

  localparam int NumSlots = 8;
  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 200;
  localparam int RandomCommands = 355;
  localparam logic [2:0] KindUnused = 3'd7;

  // one row of the directed part: a command and, where obvious, its single result
  typedef struct packed {
    in_item_t  cmd;
    logic      typed;
    out_item_t want;
  } plan_row_t;

  localparam int PlanRows = 26;
  localparam plan_row_t Plan [PlanRows] = '{
    '{'{KindTick,     3'd0, 32'd0,          32'd0},          1'b1, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindOneShot,  3'd0, 32'd0,          32'd0},          1'b1, '{RkRejected, 3'd0, 1'b1}},
    '{'{KindPeriodic, 3'd7, 32'd0,          32'hFFFFFFFF},   1'b1, '{RkRejected, 3'd0, 1'b1}},
    '{'{KindOneShot,  3'd0, 32'hFFFFFFFF,   32'd0},          1'b1, '{RkCreated,  3'd0, 1'b1}},
    '{'{KindPeriodic, 3'd0, 32'd1,          32'd0},          1'b1, '{RkCreated,  3'd1, 1'b1}},
    '{'{KindTick,     3'd0, 32'd0,          32'd0},          1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindTick,     3'd0, 32'd0,          32'd1},          1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindDisable,  3'd1, 32'd0,          32'd0},          1'b1, '{RkAck,      3'd0, 1'b1}},
    '{'{KindTick,     3'd0, 32'd0,          32'hFFFFFFFF},   1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindEnable,   3'd1, 32'd0,          32'd0},          1'b1, '{RkAck,      3'd0, 1'b1}},
    '{'{KindEnable,   3'd7, 32'd0,          32'd0},          1'b1, '{RkAck,      3'd0, 1'b1}},
    '{'{KindDisable,  3'd5, 32'd0,          32'd0},          1'b1, '{RkAck,      3'd0, 1'b1}},
    '{'{KindDelete,   3'd6, 32'd0,          32'd0},          1'b1, '{RkAck,      3'd0, 1'b1}},
    '{'{KindUnused,   3'd7, 32'hFFFFFFFF,   32'hFFFFFFFF},   1'b1, '{RkAck,      3'd0, 1'b1}},
    '{'{KindPeriodic, 3'd0, 32'h80000000,   32'd0},          1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindOneShot,  3'd0, 32'd2,          32'd0},          1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindPeriodic, 3'd0, 32'd3,          32'd0},          1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindOneShot,  3'd0, 32'h7FFFFFFF,   32'd0},          1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindPeriodic, 3'd0, 32'd5,          32'd0},          1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindOneShot,  3'd0, 32'd6,          32'd0},          1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindPeriodic, 3'd0, 32'hFFFFFFFE,   32'd0},          1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindOneShot,  3'd0, 32'd9,          32'd0},          1'b1, '{RkFull,     3'd0, 1'b1}},
    '{'{KindTick,     3'd0, 32'd0,          32'hFFFFFFFF},   1'b0, '{RkQuiet,    3'd0, 1'b1}},
    '{'{KindDelete,   3'd3, 32'd0,          32'd0},          1'b1, '{RkAck,      3'd0, 1'b1}},
    '{'{KindDeleteAll, 3'd0, 32'd0,         32'd0},          1'b1, '{RkAck,      3'd0, 1'b1}},
    '{'{KindTick,     3'd0, 32'd0,          32'hFFFFFFFF},   1'b1, '{RkQuiet,    3'd0, 1'b1}}
  };

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  // mirror of the slot table
  logic        slot_busy [NumSlots];
  logic        slot_on [NumSlots];
  logic [31:0] left_ms [NumSlots];
  logic [31:0] period_ms [NumSlots];

  out_item_t timer_results_q [$];

  int unsigned errors = 0;
  int unsigned commands_sent = 0;
  int unsigned results_seen = 0;
  int unsigned firings_seen = 0;
  int unsigned full_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          fast_mode = 1'b0;
  bit          hold_outputs = 1'b0;

  always #1 clk = ~clk;

  multi_slot_software_timer_core #(.NUM_SLOTS(NumSlots)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  function automatic out_item_t timer_result(logic [2:0] rk, logic [2:0] slot, logic last);
    out_item_t r;
    r.result_kind = rk;
    r.slot_out = slot;
    r.last = last;
    return r;
  endfunction

  // applies one command to the mirrored table and queues what it should report
  function automatic void predict_command(in_item_t c);
    int n;
    int free_slot;
    n = 0;
    free_slot = -1;
    case (c.kind)
      KindOneShot, KindPeriodic: begin
        if (c.duration == 32'd0) begin
          timer_results_q.push_back(timer_result(RkRejected, 3'd0, 1'b1));
        end else begin
          for (int i = 0; i < NumSlots; i++) begin
            if (free_slot < 0 && !slot_busy[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            timer_results_q.push_back(timer_result(RkFull, 3'd0, 1'b1));
          end else begin
            slot_busy[free_slot] = 1'b1;
            slot_on[free_slot] = 1'b1;
            left_ms[free_slot] = c.duration;
            period_ms[free_slot] = (c.kind == KindPeriodic) ? c.duration : 32'd0;
            timer_results_q.push_back(timer_result(RkCreated, 3'(free_slot), 1'b1));
          end
        end
      end
      KindTick: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (slot_busy[i] && slot_on[i]) begin
            if (left_ms[i] <= c.elapsed) begin
              if (n < MaxResults) begin
                timer_results_q.push_back(timer_result(RkFired, 3'(i), 1'b0));
                n++;
              end
              if (period_ms[i] != 32'd0) begin
                left_ms[i] = period_ms[i];
              end else begin
                slot_busy[i] = 1'b0;
                slot_on[i] = 1'b0;
              end
            end else begin
              left_ms[i] = left_ms[i] - c.elapsed;
            end
          end
        end
        if (n == 0) timer_results_q.push_back(timer_result(RkQuiet, 3'd0, 1'b1));
        else timer_results_q[timer_results_q.size() - 1].last = 1'b1;
      end
      KindDeleteAll: begin
        for (int i = 0; i < NumSlots; i++) begin
          slot_busy[i] = 1'b0;
          slot_on[i] = 1'b0;
        end
        timer_results_q.push_back(timer_result(RkAck, 3'd0, 1'b1));
      end
      KindEnable, KindDisable, KindDelete: begin
        if (int'(c.slot) < NumSlots && slot_busy[c.slot]) begin
          if (c.kind == KindEnable) begin
            slot_on[c.slot] = 1'b1;
          end else if (c.kind == KindDisable) begin
            slot_on[c.slot] = 1'b0;
          end else begin
            slot_busy[c.slot] = 1'b0;
            slot_on[c.slot] = 1'b0;
          end
        end
        timer_results_q.push_back(timer_result(RkAck, 3'd0, 1'b1));
      end
      default: begin
        timer_results_q.push_back(timer_result(RkAck, 3'd0, 1'b1));
      end
    endcase
  endfunction

  // offers one command after a random gap (none in fast mode) and records its expected results on transfer
  task automatic issue_command(input in_item_t cmd, input logic typed, input out_item_t want);
    int unsigned gap;
    int unsigned depth;
    gap = fast_mode ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = cmd;
    do @(posedge clk); while (!in_ready_o);
    depth = timer_results_q.size();
    predict_command(cmd);
    if (typed) begin
      while (timer_results_q.size() > depth) void'(timer_results_q.pop_back());
      timer_results_q.push_back(want);
    end
    commands_sent++;
    @(negedge clk);
  endtask

  // result side: random stalls per transfer outside fast mode, and one long hold on request
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (hold_outputs) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_outputs = 1'b0;
      end
      stall = fast_mode ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid_o);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      if (out_item_o.result_kind == RkFired) firings_seen++;
      if (out_item_o.result_kind == RkFull) full_seen++;
      if (timer_results_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: kind %0d slot %0d last %0d", $time,
                 out_item_o.result_kind, out_item_o.slot_out, out_item_o.last);
      end else begin
        want = timer_results_q.pop_front();
        if (want.result_kind !== out_item_o.result_kind || want.slot_out !== out_item_o.slot_out
            || want.last !== out_item_o.last) begin
          errors++;
          $display("%0t: result mismatch: expected kind %0d slot %0d last %0d, got kind %0d slot %0d last %0d",
                   $time, want.result_kind, want.slot_out, want.last,
                   out_item_o.result_kind, out_item_o.slot_out, out_item_o.last);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    in_item_t  cmd;
    out_item_t none;
    int unsigned pick;
    none = '0;
    for (int i = 0; i < NumSlots; i++) begin
      slot_busy[i] = 1'b0;
      slot_on[i] = 1'b0;
      left_ms[i] = 32'd0;
      period_ms[i] = 32'd0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    for (int r = 0; r < PlanRows; r++) begin
      issue_command(Plan[r].cmd, Plan[r].typed, Plan[r].want);
    end

    for (int n = 0; n < RandomCommands; n++) begin
      // alternate phases with and without idling on both sides
      if (n % 60 == 0) fast_mode = (n / 60) % 2 == 1;
      if (n == 120) hold_outputs = 1'b1;
      if (n == 240) begin
        in_valid = 1'b0;
        while (timer_results_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      cmd.slot = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 19);
      if (pick == 0) cmd.duration = 32'd0;
      else if (pick == 1) cmd.duration = $urandom();
      else if (pick == 2) cmd.duration = 32'hFFFFFFFF;
      else cmd.duration = 32'($urandom_range(1, 40));
      pick = $urandom_range(0, 19);
      if (pick == 0) cmd.elapsed = 32'd0;
      else if (pick == 1) cmd.elapsed = $urandom();
      else if (pick == 2) cmd.elapsed = 32'hFFFFFFFF;
      else cmd.elapsed = 32'($urandom_range(0, 25));
      pick = $urandom_range(0, 99);
      if (pick < 16) cmd.kind = KindOneShot;
      else if (pick < 32) cmd.kind = KindPeriodic;
      else if (pick < 57) cmd.kind = KindTick;
      else if (pick < 67) cmd.kind = KindEnable;
      else if (pick < 77) cmd.kind = KindDisable;
      else if (pick < 89) cmd.kind = KindDelete;
      else if (pick < 93) cmd.kind = KindDeleteAll;
      else cmd.kind = KindUnused;
      issue_command(cmd, 1'b0, none);
    end

    in_valid = 1'b0;
    while (timer_results_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("commands %0d, results %0d, of which %0d firings and %0d table-full reports",
             commands_sent, results_seen, firings_seen, full_seen);
    $display("mismatches %0d", errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/mst_pkg.sv
hdl/mst_tick_unit.sv
hdl/multi_slot_software_timer_core.sv
tb/tb.sv
